// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on i_clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`else

`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)

`endif

`endif

// ----- rtl/core/cbmi_pkg.sv -----
// ----------------------------------------------------------------------------
// cbmi_pkg
// Shared types and constants of the capped body motion integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package cbmi_pkg;

    localparam int DATA_W    = 32;
    localparam int DT_W      = 16;
    localparam int CAP_W     = 31;
    localparam int CFG_IDX_W = 3;
    localparam int MUL_A_W   = 34;
    localparam int PROD_W    = MUL_A_W + DT_W + 1;

    // Q16.16 constants
    localparam logic signed [DATA_W-1:0] GRAVITY_Y     = -32'sd642253;
    localparam logic signed [DATA_W-1:0] GRAVITY_LIMIT = -32'sd2293760;
    localparam logic [CAP_W-1:0]         CAP_RESET     = 31'd3932160;

    typedef enum logic [0:0] {
        OP_TICK      = 1'b0,
        OP_SET_ACCEL = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BODY_STATIC    = 3'd0,
        CFG_GRAVITY_ENABLE = 3'd1,
        CFG_DRAG_ENABLE    = 3'd2,
        CFG_SPEED_CAP_X    = 3'd3,
        CFG_SPEED_CAP_Y    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic             body_static;
        logic             gravity_enable;
        logic             drag_enable;
        logic [CAP_W-1:0] speed_cap_x;
        logic [CAP_W-1:0] speed_cap_y;
    } t_cfg;

    typedef struct packed {
        logic signed [DATA_W-1:0] move_x;
        logic signed [DATA_W-1:0] move_y;
        logic signed [DATA_W-1:0] speed_x;
        logic signed [DATA_W-1:0] speed_y;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLAMP,
        S_MUL,
        S_DONE
    } t_state;

    // multiplier schedule, one operand per step
    typedef enum logic [2:0] {
        STEP_AX_DT   = 3'd0,
        STEP_VX_DT   = 3'd1,
        STEP_ADTX_DT = 3'd2,
        STEP_AY_DT   = 3'd3,
        STEP_VY_DT   = 3'd4,
        STEP_ADTY_DT = 3'd5,
        STEP_AYG_DT  = 3'd6,
        STEP_VEL_Y   = 3'd7
    } t_step;

endpackage

`default_nettype wire

// ----- rtl/core/cbmi_cfg.sv -----
// ----------------------------------------------------------------------------
// cbmi_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module cbmi_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [cbmi_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [cbmi_pkg::CAP_W-1:0]     i_cfg_data,
    output cbmi_pkg::t_cfg                      o_cfg
);
    import cbmi_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.body_static    <= 1'b0;
            r_cfg.gravity_enable <= 1'b0;
            r_cfg.drag_enable    <= 1'b0;
            r_cfg.speed_cap_x    <= CAP_RESET;
            r_cfg.speed_cap_y    <= CAP_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BODY_STATIC:    r_cfg.body_static    <= i_cfg_data[0];
                CFG_GRAVITY_ENABLE: r_cfg.gravity_enable <= i_cfg_data[0];
                CFG_DRAG_ENABLE:    r_cfg.drag_enable    <= i_cfg_data[0];
                CFG_SPEED_CAP_X:    r_cfg.speed_cap_x    <= i_cfg_data;
                CFG_SPEED_CAP_Y:    r_cfg.speed_cap_y    <= i_cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- rtl/core/cbmi_mul.sv -----
// ----------------------------------------------------------------------------
// cbmi_mul
// Shared signed by time-step multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module cbmi_mul (
    input  wire logic                                i_clk,
    input  wire logic signed [cbmi_pkg::MUL_A_W-1:0] i_a,
    input  wire logic [cbmi_pkg::DT_W-1:0]           i_dt,
    output logic signed [cbmi_pkg::PROD_W-1:0]       o_prod
);
    import cbmi_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [DT_W:0]     dt_s;

    assign dt_s = $signed({1'b0, i_dt});

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(dt_s);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ----- rtl/core/cbmi_seq.sv -----
// ----------------------------------------------------------------------------
// cbmi_seq
// Tick sequencer and datapath: clamp, schedule of seven products through
// the shared multiplier, displacement, velocity update and drag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cbmi_seq (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire cbmi_pkg::t_cfg                      i_cfg,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_opcode,
    input  wire logic [cbmi_pkg::DT_W-1:0]           i_time_step,
    input  wire logic signed [cbmi_pkg::DATA_W-1:0]  i_accel_x_in,
    input  wire logic signed [cbmi_pkg::DATA_W-1:0]  i_accel_y_in,
    output logic signed [cbmi_pkg::MUL_A_W-1:0]      o_mul_a,
    output logic [cbmi_pkg::DT_W-1:0]                o_mul_dt,
    input  wire logic signed [cbmi_pkg::PROD_W-1:0]  i_prod,
    output logic                                     o_res_valid,
    input  wire logic                                i_res_ready,
    output cbmi_pkg::t_result                        o_res
);
    import cbmi_pkg::*;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W+1:0] x);
        logic signed [DATA_W+1:0] hi;
        logic signed [DATA_W+1:0] lo;
        hi = (DATA_W+2)'({1'b0, {(DATA_W-1){1'b1}}});
        lo = -hi - (DATA_W+2)'(1);
        if (x > hi) begin
            return hi[DATA_W-1:0];
        end else if (x < lo) begin
            return lo[DATA_W-1:0];
        end
        return x[DATA_W-1:0];
    endfunction

    t_state r_state, n_state;
    t_step  r_step;

    logic signed [DATA_W-1:0] r_vel_x, r_vel_y;
    logic signed [DATA_W-1:0] r_acc_x, r_acc_y;
    logic signed [DATA_W-1:0] r_vx, r_vy;      // clamped velocity
    logic signed [DATA_W:0]   r_ay_g;          // y acceleration with gravity
    logic signed [DATA_W-1:0] r_adt;           // floor(a*dt / 2^16)
    logic signed [48:0]       r_acc;           // v*dt
    logic signed [DATA_W-1:0] r_mx, r_my;
    logic [DT_W-1:0]          r_dt;

    logic                     accept;
    logic signed [DATA_W-1:0] cap_x, cap_y;
    logic signed [DATA_W-1:0] clamp_x, clamp_y;
    logic signed [DATA_W-1:0] disp;
    logic signed [48:0]       disp_sum;
    logic signed [DATA_W-1:0] vel_x_new, vel_y_new, vel_x_drag;
    logic signed [DATA_W:0]   drag_s, drag_d;
    logic [19:0]              drag;

    assign accept = i_in_valid && o_in_ready;

    // ---- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && t_opcode'(i_opcode) == OP_TICK) begin
                    n_state = i_cfg.body_static ? S_DONE : S_CLAMP;
                end
            end
            S_CLAMP: n_state = S_MUL;
            S_MUL: begin
                if (r_step == STEP_VEL_Y) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---- outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_ready  = 1'b1;
            S_DONE:  o_res_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_res.move_x  = r_mx;
    assign o_res.move_y  = r_my;
    assign o_res.speed_x = r_vel_x;
    assign o_res.speed_y = r_vel_y;

    // ---- multiplier operand
    always_comb begin
        case (r_step)
            STEP_AX_DT:   o_mul_a = MUL_A_W'(r_acc_x);
            STEP_VX_DT:   o_mul_a = MUL_A_W'(r_vx);
            STEP_ADTX_DT: o_mul_a = MUL_A_W'(r_adt);
            STEP_AY_DT:   o_mul_a = MUL_A_W'(r_acc_y);
            STEP_VY_DT:   o_mul_a = MUL_A_W'(r_vy);
            STEP_ADTY_DT: o_mul_a = MUL_A_W'(r_adt);
            default:      o_mul_a = MUL_A_W'(r_ay_g);
        endcase
    end
    assign o_mul_dt = r_dt;

    // ---- datapath helpers
    assign cap_x   = $signed({1'b0, i_cfg.speed_cap_x});
    assign cap_y   = $signed({1'b0, i_cfg.speed_cap_y});
    assign clamp_x = (r_vel_x > cap_x) ? cap_x : ((r_vel_x < -cap_x) ? -cap_x : r_vel_x);
    assign clamp_y = (r_vel_y > cap_y) ? cap_y : ((r_vel_y < -cap_y) ? -cap_y : r_vel_y);

    // v*dt + floor(adt*dt / 2), then floor / 2^16
    assign disp_sum = r_acc + 49'($signed(i_prod[47:1]));
    assign disp     = sat32((DATA_W+2)'($signed(disp_sum[48:16])));

    assign vel_x_new = sat32((DATA_W+2)'(r_vx) + (DATA_W+2)'(r_adt));
    assign vel_y_new = sat32((DATA_W+2)'(r_vy) + (DATA_W+2)'($signed(i_prod[48:16])));

    // drag = 14*dt, moves x velocity toward zero without crossing
    assign drag   = {r_dt, 4'b0} - {3'b0, r_dt, 1'b0};
    assign drag_s = $signed({13'b0, drag});
    always_comb begin
        drag_d     = '0;
        vel_x_drag = r_vel_x;
        if (r_vel_x > 0) begin
            drag_d     = (DATA_W+1)'(r_vel_x) - drag_s;
            vel_x_drag = (drag_d <= 0) ? '0 : drag_d[DATA_W-1:0];
        end else if (r_vel_x < 0) begin
            drag_d     = (DATA_W+1)'(r_vel_x) + drag_s;
            vel_x_drag = (drag_d >= 0) ? '0 : drag_d[DATA_W-1:0];
        end
    end

    // ---- control and body state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= STEP_AX_DT;
            r_vel_x <= '0;
            r_vel_y <= '0;
            r_acc_x <= '0;
            r_acc_y <= '0;
        end else begin
            r_state <= n_state;
            if (accept && t_opcode'(i_opcode) == OP_SET_ACCEL) begin
                r_acc_x <= i_accel_x_in;
                r_acc_y <= i_accel_y_in;
            end
            if (r_state == S_MUL) begin
                r_step <= t_step'(r_step + 3'd1);
                case (r_step)
                    STEP_AY_DT:  r_vel_x <= vel_x_new;
                    STEP_VY_DT:  r_vel_x <= i_cfg.drag_enable ? vel_x_drag : r_vel_x;
                    STEP_VEL_Y: begin
                        r_vel_y <= vel_y_new;
                        r_acc_x <= '0;
                        r_acc_y <= '0;
                    end
                    default: ;
                endcase
            end else begin
                r_step <= STEP_AX_DT;
            end
        end
    end

    // ---- working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dt <= i_time_step;
            r_mx <= '0;
            r_my <= '0;
        end
        if (r_state == S_CLAMP) begin
            r_vx <= clamp_x;
            r_vy <= clamp_y;
        end
        if (r_state == S_MUL) begin
            case (r_step)
                STEP_AX_DT: begin
                    r_ay_g <= (DATA_W+1)'(r_acc_y) +
                              ((i_cfg.gravity_enable && r_vy > GRAVITY_LIMIT) ?
                               (DATA_W+1)'(GRAVITY_Y) : '0);
                end
                STEP_VX_DT:   r_adt <= i_prod[47:16];
                STEP_ADTX_DT: r_acc <= i_prod[48:0];
                STEP_AY_DT:   r_mx  <= disp;
                STEP_VY_DT:   r_adt <= i_prod[47:16];
                STEP_ADTY_DT: r_acc <= i_prod[48:0];
                STEP_AYG_DT:  r_my  <= disp;
                default: ;
            endcase
        end
    end

    // ---- checks
    `ASSERT_NEVER(a_ready_while_result, o_in_ready && o_res_valid, "ready while result pending")
    `ASSERT_PROP(a_static_tick_direct, accept && t_opcode'(i_opcode) == OP_TICK && i_cfg.body_static |=> o_res_valid && r_mx == 0 && r_my == 0, "static tick must give zero move")
    `ASSERT_PROP(a_set_accel_no_result, accept && t_opcode'(i_opcode) == OP_SET_ACCEL |=> o_in_ready, "set acceleration must not start a tick")
    `ASSERT_PROP(a_result_held, o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res), "result changed while stalled")
    `ASSERT_PROP(a_step_idle, r_state != S_MUL |=> r_step == STEP_AX_DT, "step counter not rewound")

endmodule

`default_nettype wire

// ----- rtl/core/capped_body_motion_integrator.sv -----
// ----------------------------------------------------------------------------
// capped_body_motion_integrator
// 2-D Euler motion step for one body in Q16.16, with speed caps, gravity
// and horizontal drag; top level with output register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_ready carries opcode, time step and
//   acceleration. A set-acceleration transaction stores the pending
//   acceleration and gives no result; the block is ready again next cycle.
//   A tick transaction produces one result (move and speed) on the
//   o_out_valid / i_out_ready channel.
//   A moving tick goes from acceptance through the clamp state and the
//   schedule of the shared 34x17 multiplier, which forms the seven
//   products of the step, and then loads the output register.
//   A tick of a static body skips both and goes straight to the result
//   state. Input is accepted only once the sequencer is idle, so a new
//   transaction is not taken before the previous tick has finished.
//   The output register holds a result while the receiver stalls; the
//   sequencer can accept and compute the next transaction meanwhile and
//   waits only when it has a second result ready.
//   Reset (synchronous, active low) clears velocity and pending
//   acceleration, restores the configuration defaults and empties the
//   output register. Configuration is written through i_cfg_we; the user
//   must do so only while idle, as the block itself does not enforce it.
`default_nettype none

module capped_body_motion_integrator (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [cbmi_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [cbmi_pkg::CAP_W-1:0]          i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_opcode,
    input  wire logic [cbmi_pkg::DT_W-1:0]           i_time_step,
    input  wire logic signed [cbmi_pkg::DATA_W-1:0]  i_accel_x_in,
    input  wire logic signed [cbmi_pkg::DATA_W-1:0]  i_accel_y_in,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [cbmi_pkg::DATA_W-1:0]       o_move_x,
    output logic signed [cbmi_pkg::DATA_W-1:0]       o_move_y,
    output logic signed [cbmi_pkg::DATA_W-1:0]       o_speed_x,
    output logic signed [cbmi_pkg::DATA_W-1:0]       o_speed_y
);
    import cbmi_pkg::*;

    t_cfg                     cfg;
    t_result                  res;
    t_result                  r_out;
    logic                     r_out_valid;
    logic                     res_valid;
    logic                     res_ready;
    logic signed [MUL_A_W-1:0] mul_a;
    logic [DT_W-1:0]          mul_dt;
    logic signed [PROD_W-1:0] prod;

    cbmi_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    cbmi_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_dt   (mul_dt),
        .o_prod (prod)
    );

    cbmi_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_time_step  (i_time_step),
        .i_accel_x_in (i_accel_x_in),
        .i_accel_y_in (i_accel_y_in),
        .o_mul_a      (mul_a),
        .o_mul_dt     (mul_dt),
        .i_prod       (prod),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    // output register frees the sequencer while the receiver stalls
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_move_x    = r_out.move_x;
    assign o_move_y    = r_out.move_y;
    assign o_speed_x   = r_out.speed_x;
    assign o_speed_y   = r_out.speed_y;

endmodule

`default_nettype wire
